@@ design/tpdv_pkg.sv @@
package tpdv_pkg;

	localparam int DIV_STEPS = 3;
	localparam int DIV_STAGES = 6;
	localparam int QW = DIV_STEPS * DIV_STAGES;

	localparam logic [1:0] REG_HALF = 2'd0;
	localparam logic [1:0] REG_MAX = 2'd1;
	localparam logic [1:0] REG_MIN = 2'd2;

	typedef struct packed {
		logic [15:0]   r;
		logic [QW-1:0] low;
		logic [QW-1:0] q;
	} div_t;

	typedef div_t [2:0] div3_t;

	typedef struct packed {
		logic             frac;
		logic [2:0]       vsign;
		logic [2:0]       ovf;
		logic [2:0][16:0] fr;
	} side_t;

	function automatic div_t div_step(div_t d, logic [15:0] bus);
		logic [16:0] t;
		div_t o;
		t = {d.r, d.low[QW-1]};
		o.low = {d.low[QW-2:0], 1'b0};
		if (t >= {1'b0, bus}) begin
			o.r = 16'(t - {1'b0, bus});
			o.q = {d.q[QW-2:0], 1'b1};
		end else begin
			o.r = t[15:0];
			o.q = {d.q[QW-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

@@ design/tpdv_if.sv @@
interface tpdv_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] phase_u;
	logic [15:0] phase_v;
	logic [15:0] phase_w;
	logic [15:0] bus_voltage;

	modport source(output valid, cmd, phase_u, phase_v, phase_w, bus_voltage, input ready);
	modport sink(input valid, cmd, phase_u, phase_v, phase_w, bus_voltage, output ready);
endinterface

interface tpdv_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] ticks_u;
	logic [15:0] ticks_v;
	logic [15:0] ticks_w;
	logic        saturated;

	modport source(output valid, ticks_u, ticks_v, ticks_w, saturated, input ready);
	modport sink(input valid, ticks_u, ticks_v, ticks_w, saturated, output ready);
endinterface

@@ design/tpdv_div_stage.sv @@
module tpdv_div_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  tpdv_pkg::div3_t     din,
	input  tpdv_pkg::side_t     side_in,
	input  logic [15:0]         bus_in,
	output logic                vout,
	output tpdv_pkg::div3_t     dout,
	output tpdv_pkg::side_t     side_out,
	output logic [15:0]         bus_out
);

	tpdv_pkg::div3_t nxt;

	always_comb begin
		nxt = din;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < tpdv_pkg::DIV_STEPS; k++) begin
				nxt[c] = tpdv_pkg::div_step(nxt[c], bus_in);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
			side_out <= side_in;
			bus_out <= bus_in;
		end
	end

endmodule

@@ design/three_phase_duty_from_voltage_unit.sv @@
// Three-phase PWM compare generator. Each request carries three signed phase
// commands and returns three clamped compare values and a saturation flag. One
// request is taken every clock cycle unless a stalled output holds the
// pipeline. The restoring divider resolves three quotient bits per pipeline
// stage over six stages. A stalled output holds the pipeline in place and empty
// stages keep filling, so nothing is lost or repeated. Write the half period,
// maximum and minimum registers only while the block is idle.
module three_phase_duty_from_voltage_unit (
	input  logic        clk,
	input  logic        arst_n,
	tpdv_in_if.sink     in_ch,
	tpdv_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int NS = tpdv_pkg::DIV_STAGES;
	localparam int QW = tpdv_pkg::QW;

	logic [14:0] half_q;
	logic [15:0] max_q;
	logic [15:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 15'd2500;
			max_q <= 16'd4750;
			min_q <= 16'd250;
		end else if (cfg_we) begin
			case (cfg_index)
				tpdv_pkg::REG_HALF: half_q <= cfg_data[14:0];
				tpdv_pkg::REG_MAX: max_q <= cfg_data;
				tpdv_pkg::REG_MIN: min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s9, v_s10;
	logic en_s1, en_s2, en_s9, en_s10;
	logic [NS:1] vd;
	logic [NS:1] en_d;

	assign en_s10 = !v_s10 || out_ch.ready;
	assign en_s9 = !v_s9 || en_s10;
	assign en_d[NS] = !vd[NS] || en_s9;
	for (genvar k = 1; k < NS; k++) begin : g_en
		assign en_d[k] = !vd[k] || en_d[k+1];
	end
	assign en_s2 = !v_s2 || en_d[1];
	assign en_s1 = !v_s1 || en_s2;
	assign in_ch.ready = en_s1;

	// Stage 1: products of command and half period.
	logic [2:0][15:0] ph;
	logic [2:0][31:0] p_s1;
	logic             frac_s1;
	logic [2:0]       vsign_s1;
	logic [15:0]      bus_s1;

	assign ph[0] = in_ch.phase_u;
	assign ph[1] = in_ch.phase_v;
	assign ph[2] = in_ch.phase_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int c = 0; c < 3; c++) begin
				p_s1[c] <= 32'($signed({{16{ph[c][15]}}, ph[c]}) * $signed({17'b0, half_q}));
				vsign_s1[c] <= ph[c][15];
			end
			frac_s1 <= in_ch.cmd;
			bus_s1 <= in_ch.bus_voltage;
		end
	end

	// Stage 2: magnitude, overflow check and divider setup.
	tpdv_pkg::div3_t  d_s2;
	tpdv_pkg::side_t  side_s2;
	logic [15:0]      bus_s2;
	tpdv_pkg::div3_t  d_in;
	tpdv_pkg::side_t  side_in;
	logic [2:0][31:0] mag;

	always_comb begin
		side_in.frac = frac_s1;
		side_in.vsign = vsign_s1;
		for (int c = 0; c < 3; c++) begin
			mag[c] = p_s1[c][31] ? 32'(-{p_s1[c][30:0], 1'b0}) : {p_s1[c][30:0], 1'b0};
			side_in.ovf[c] = {1'b0, mag[c][31:17]} >= bus_s1;
			side_in.fr[c] = p_s1[c][31:15];
			d_in[c].r = {2'b0, mag[c][31:QW]};
			d_in[c].low = mag[c][QW-1:0];
			d_in[c].q = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			d_s2 <= d_in;
			side_s2 <= side_in;
			bus_s2 <= bus_s1;
		end
	end

	// Divider stages.
	tpdv_pkg::div3_t dd [0:NS];
	tpdv_pkg::side_t sd [0:NS];
	logic [15:0]     bd [0:NS];
	logic [NS:0]     vdd;

	assign dd[0] = d_s2;
	assign sd[0] = side_s2;
	assign bd[0] = bus_s2;
	assign vdd[0] = v_s2;

	for (genvar k = 1; k <= NS; k++) begin : g_div
		tpdv_div_stage u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en_d[k]),
			.vin(vdd[k-1]),
			.din(dd[k-1]),
			.side_in(sd[k-1]),
			.bus_in(bd[k-1]),
			.vout(vdd[k]),
			.dout(dd[k]),
			.side_out(sd[k]),
			.bus_out(bd[k])
		);
		assign vd[k] = vdd[k];
	end

	// Stage 9: unclamped compare values.
	logic [2:0][19:0] raw_s9;
	logic             frac_s9;
	logic [2:0][19:0] raw_c;
	logic [2:0][18:0] qr;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qr[c] = {1'b0, dd[NS][c].q} + 19'(dd[NS][c].r != 16'd0);
			if (sd[NS].frac) begin
				raw_c[c] = 20'($signed(sd[NS].fr[c])) + {5'b0, half_q};
			end else if (sd[NS].ovf[c]) begin
				raw_c[c] = sd[NS].vsign[c] ? 20'hFFFFF : 20'h7FFFF;
			end else if (sd[NS].vsign[c]) begin
				raw_c[c] = 20'({5'b0, half_q} - {1'b0, qr[c]});
			end else begin
				raw_c[c] = {2'b0, dd[NS][c].q} + {5'b0, half_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en_s9) begin
			v_s9 <= vd[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s9) begin
			raw_s9 <= raw_c;
			frac_s9 <= sd[NS].frac;
		end
	end

	// Stage 10: clamp and flag.
	logic [2:0][15:0] t_c;
	logic [2:0][15:0] t_s10;
	logic [2:0][19:0] hi_c;
	logic             sat_c;
	logic             sat_s10;

	always_comb begin
		sat_c = 1'b0;
		for (int c = 0; c < 3; c++) begin
			hi_c[c] = ($signed(raw_s9[c]) > $signed({4'b0, max_q})) ? {4'b0, max_q} : raw_s9[c];
			t_c[c] = ($signed(hi_c[c]) < $signed({4'b0, min_q})) ? min_q : hi_c[c][15:0];
			if (t_c[c] == max_q || t_c[c] == min_q) begin
				sat_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en_s10) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			t_s10 <= t_c;
			sat_s10 <= sat_c && !frac_s9;
		end
	end

	assign out_ch.valid = v_s10;
	assign out_ch.ticks_u = t_s10[0];
	assign out_ch.ticks_v = t_s10[1];
	assign out_ch.ticks_w = t_s10[2];
	assign out_ch.saturated = sat_s10;

endmodule
